// File: design/gdrm_pkg.sv
// ----------------------------------------------------------------------------
// gdrm_pkg: shared types and constants of the greedy delta-R matcher
// Field widths, the candidate cell record and the stored reference record.
// ----------------------------------------------------------------------------
package gdrm_pkg;

	localparam int PT_W     = 16;
	localparam int ETA_W    = 13;
	localparam int PHI_W    = 12;
	localparam int CUT_W    = 24;
	localparam int DIST_W   = 25;
	localparam int OIDX_W   = 4;
	localparam int DATA_W   = 24;
	localparam int ACTION_W = 2;

	localparam logic [ACTION_W-1:0] ACT_LOAD_REF  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_LOAD_CAND = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_START     = 2'd2;
	// The remaining action code does nothing.
	localparam logic [ACTION_W-1:0] ACT_NONE      = 2'd3;

	localparam logic REG_CUT = 1'b0;
	localparam logic REG_PT  = 1'b1;

	localparam logic [DIST_W-1:0] DIST_MAX     = '1;
	localparam logic [CUT_W-1:0]  CUT_RESET    = 24'd4251;
	localparam logic [PT_W-1:0]   PT_THR_RESET = 16'd20;

	typedef struct packed {
		logic [PT_W-1:0]         pt;
		logic signed [ETA_W-1:0] eta;
		logic signed [PHI_W-1:0] phi;
	} ref_t;

	typedef struct packed {
		logic                    valid;
		logic                    used;
		logic signed [ETA_W-1:0] eta;
		logic signed [PHI_W-1:0] phi;
	} cand_t;

	typedef struct packed {
		logic shift;
		logic clr;
	} cell_ctl_t;

endpackage

// File: design/gdrm_if.sv
// ----------------------------------------------------------------------------
// gdrm_if: channel interfaces of the matcher
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface gdrm_req_if;
	logic                           valid;
	logic                           ready;
	logic [gdrm_pkg::ACTION_W-1:0]  action;
	logic [gdrm_pkg::PT_W-1:0]      pt;
	logic signed [gdrm_pkg::ETA_W-1:0] eta;
	logic signed [gdrm_pkg::PHI_W-1:0] phi;
	modport source (output valid, action, pt, eta, phi, input ready);
	modport sink (input valid, action, pt, eta, phi, output ready);
endinterface

interface gdrm_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          found;
	logic [gdrm_pkg::OIDX_W-1:0]   ref_index;
	logic [gdrm_pkg::OIDX_W-1:0]   cand_index;
	logic [gdrm_pkg::DIST_W-1:0]   dist_sq;
	logic                          last;
	modport source (output valid, found, ref_index, cand_index, dist_sq, last, input ready);
	modport sink (input valid, found, ref_index, cand_index, dist_sq, last, output ready);
endinterface

interface gdrm_cfg_if;
	logic                          valid;
	logic                          ready;
	logic                          index;
	logic [gdrm_pkg::DATA_W-1:0]   data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: design/greedy_delta_r_matcher_core.sv
// Operation: a load writes its record when it is accepted; a start opens a run
// that shows one result per decide step, and each decide step waits while the
// result register holds a result that rsp.ready has not taken. All pairs are
// scored by the single distance unit. Requests are taken one at a time; a start
// holds the block until its run ends, output stalls included.
// Reset: arst_n clears counts, used flags, cells, result and handshake state at once.
// ----------------------------------------------------------------------------
// greedy_delta_r_matcher_core: greedy delta-R pairing of references and candidates
// Candidates sit in a rotating ring of cells; references sit in a memory.
// ----------------------------------------------------------------------------
module greedy_delta_r_matcher_core #(
	parameter int MAX_PARTICLES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	gdrm_req_if.sink    req,
	gdrm_rsp_if.source  rsp,
	gdrm_cfg_if.sink    cfg
);
	import gdrm_pkg::*;

	localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_PARTICLES - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_PARTICLES);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE
	} state_t;

	state_t state_q;

	// Configuration registers. Writes are taken at any time.
	logic [CUT_W-1:0] cut_q;
	logic [PT_W-1:0]  pt_thr_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cut_q    <= CUT_RESET;
			pt_thr_q <= PT_THR_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_CUT: cut_q    <= cfg.data;
				REG_PT:  pt_thr_q <= PT_W'(cfg.data);
				default: ;
			endcase
		end
	end

	// Reference storage: a memory written at the fill count during loads and
	// read at the scan pointer, with the read data registered.
	ref_t ref_mem [MAX_PARTICLES];
	ref_t ref_rd_q;
	logic [MAX_PARTICLES-1:0] ref_used_q;
	logic [CNT_W-1:0] ref_cnt_q, cand_cnt_q;
	logic [IDX_W-1:0] ri_q, cj_q;
	logic [1:0] drain_q;

	logic req_fire;
	logic ld_ref, ld_cand;
	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign ld_ref  = req_fire && (req.action == ACT_LOAD_REF) && (ref_cnt_q != CNT_FULL);
	assign ld_cand = req_fire && (req.action == ACT_LOAD_CAND) && (cand_cnt_q != CNT_FULL);

	always_ff @(posedge clk) begin
		if (ld_ref) begin
			ref_mem[IDX_W'(ref_cnt_q)] <= '{pt: req.pt, eta: req.eta, phi: req.phi};
		end
		ref_rd_q <= ref_mem[ri_q];
	end

	// Candidate ring. Outside a scan, cell k holds candidate k. During a scan the
	// ring rotates by one each cycle, so cell 0 shows candidate j at scan step j,
	// and after a full turn it is back in load order.
	cand_t     cell_cur [MAX_PARTICLES];
	cell_ctl_t cell_ctl;
	cand_t     cand_ld;
	logic      out_free;
	logic      take_pair;
	logic [IDX_W-1:0] best_ri_q, best_cj_q;

	assign cand_ld = '{valid: 1'b1, used: 1'b0, eta: req.eta, phi: req.phi};
	assign cell_ctl.shift = (state_q == ST_SCAN);

	for (genvar k = 0; k < MAX_PARTICLES; k++) begin : g_cell
		gdrm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (cell_ctl),
			.ld       (ld_cand && (IDX_W'(cand_cnt_q) == IDX_W'(k))),
			.ld_data  (cand_ld),
			.set_used (take_pair && (best_cj_q == IDX_W'(k))),
			.nbr      (cell_cur[(k + 1) % MAX_PARTICLES]),
			.cur      (cell_cur[k])
		);
	end

	// A reference takes part when it is loaded, unused and at or above the
	// pt threshold; a candidate when it is loaded and unused.
	logic ref_ok;
	logic pair_ok;
	assign ref_ok = (CNT_W'(ri_q) < ref_cnt_q) && !ref_used_q[ri_q] && (ref_rd_q.pt >= pt_thr_q);
	assign pair_ok = (state_q == ST_SCAN) && ref_ok && cell_cur[0].valid && !cell_cur[0].used;

	logic               dv;
	logic [2*IDX_W-1:0] dtag;
	logic [DIST_W-1:0]  dd;

	gdrm_dist #(
		.TAG_W (2 * IDX_W)
	) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pair_ok),
		.in_tag    ({ri_q, cj_q}),
		.ref_eta   (ref_rd_q.eta),
		.ref_phi   (ref_rd_q.phi),
		.cand_eta  (cell_cur[0].eta),
		.cand_phi  (cell_cur[0].phi),
		.out_valid (dv),
		.out_tag   (dtag),
		.out_dist  (dd)
	);

	// Running best of the round. Pairs arrive in reference-major, candidate-minor
	// order, so a strict compare keeps the first of equal distances.
	logic              have_q;
	logic [DIST_W-1:0] best_q;
	logic              clr_best;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (clr_best) begin
			have_q <= 1'b0;
		end else if (dv && (!have_q || dd < best_q)) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (dv && (!have_q || dd < best_q)) begin
			best_q    <= dd;
			best_ri_q <= dtag[2*IDX_W-1:IDX_W];
			best_cj_q <= dtag[IDX_W-1:0];
		end
	end

	// Result register; the next result of a run waits only for it to drain.
	logic              rsp_valid_q, rsp_found_q, rsp_last_q;
	logic [OIDX_W-1:0] rsp_ri_q, rsp_ci_q;
	logic [DIST_W-1:0] rsp_dist_q;
	logic              match_ok;

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign match_ok  = have_q && (best_q <= DIST_W'(cut_q));
	assign take_pair = (state_q == ST_DECIDE) && out_free && match_ok;
	assign clr_best  = (state_q == ST_DECIDE) && out_free;
	assign cell_ctl.clr = (state_q == ST_DECIDE) && out_free && !match_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ref_cnt_q   <= '0;
			cand_cnt_q  <= '0;
			ref_used_q  <= '0;
			ri_q        <= '0;
			cj_q        <= '0;
			drain_q     <= '0;
			rsp_valid_q <= 1'b0;
			rsp_found_q <= 1'b0;
			rsp_last_q  <= 1'b0;
			rsp_ri_q    <= '0;
			rsp_ci_q    <= '0;
			rsp_dist_q  <= '0;
		end else begin
			// A result taken in the same cycle as a new one is written is
			// replaced by the decide step below.
			if (rsp_valid_q && rsp.ready && !clr_best) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (ld_ref) begin
						ref_cnt_q <= ref_cnt_q + 1'b1;
					end
					if (ld_cand) begin
						cand_cnt_q <= cand_cnt_q + 1'b1;
					end
					if (req_fire && (req.action == ACT_START)) begin
						ri_q    <= '0;
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					cj_q    <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					cj_q <= cj_q + 1'b1;
					if (cj_q == IDX_LAST) begin
						if (ri_q == IDX_LAST) begin
							drain_q <= '0;
							state_q <= ST_DRAIN;
						end else begin
							ri_q    <= ri_q + 1'b1;
							state_q <= ST_FETCH;
						end
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q + 1'b1;
					if (drain_q == 2'd2) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						if (match_ok) begin
							rsp_found_q <= 1'b1;
							rsp_last_q  <= 1'b0;
							rsp_ri_q    <= OIDX_W'(best_ri_q);
							rsp_ci_q    <= OIDX_W'(best_cj_q);
							rsp_dist_q  <= best_q;
							ref_used_q[best_ri_q] <= 1'b1;
							ri_q    <= '0;
							state_q <= ST_FETCH;
						end else begin
							rsp_found_q <= 1'b0;
							rsp_last_q  <= 1'b1;
							rsp_ri_q    <= '0;
							rsp_ci_q    <= '0;
							rsp_dist_q  <= '0;
							ref_used_q  <= '0;
							ref_cnt_q   <= '0;
							cand_cnt_q  <= '0;
							state_q     <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.found      = rsp_found_q;
	assign rsp.ref_index  = rsp_ri_q;
	assign rsp.cand_index = rsp_ci_q;
	assign rsp.dist_sq    = rsp_dist_q;
	assign rsp.last       = rsp_last_q;

`ifndef ASSERT_OFF
	// A result never both carries a pair and closes the run.
	a_found_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.found && rsp.last))
		else $error("result with found and last both set");

	// Between runs no reference is marked used.
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (ref_used_q == '0))
		else $error("reference used flag left set while idle");

	// A new pair result always lies within the cutoff in force when it was chosen.
	a_pair_in_cut: assert property (@(posedge clk) disable iff (!arst_n)
		take_pair |=> (rsp_dist_q <= DIST_W'($past(cut_q))))
		else $error("pair emitted beyond the cutoff");
`endif
endmodule

// File: design/gdrm_cell.sv
// ----------------------------------------------------------------------------
// gdrm_cell: one candidate cell of the rotating ring
// Holds one candidate, loads it, marks it used, clears it and passes it to its neighbor.
// ----------------------------------------------------------------------------
module gdrm_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  gdrm_pkg::cell_ctl_t ctl,
	input  logic                ld,
	input  gdrm_pkg::cand_t     ld_data,
	input  logic                set_used,
	input  gdrm_pkg::cand_t     nbr,
	output gdrm_pkg::cand_t     cur
);
	import gdrm_pkg::*;

	cand_t cand_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
		end else if (ctl.clr) begin
			cand_q.valid <= 1'b0;
			cand_q.used  <= 1'b0;
		end else if (ctl.shift) begin
			cand_q <= nbr;
		end else if (ld) begin
			cand_q <= ld_data;
		end else if (set_used) begin
			cand_q.used <= 1'b1;
		end
	end

	assign cur = cand_q;
endmodule

// File: design/gdrm_dist.sv
// ----------------------------------------------------------------------------
// gdrm_dist: pipelined squared delta-R unit
// Difference with phi wrap, squares, then saturated sum over three stages.
// ----------------------------------------------------------------------------
module gdrm_dist #(
	parameter int TAG_W = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic [TAG_W-1:0]                    in_tag,
	input  logic signed [gdrm_pkg::ETA_W-1:0]   ref_eta,
	input  logic signed [gdrm_pkg::PHI_W-1:0]   ref_phi,
	input  logic signed [gdrm_pkg::ETA_W-1:0]   cand_eta,
	input  logic signed [gdrm_pkg::PHI_W-1:0]   cand_phi,
	output logic                                out_valid,
	output logic [TAG_W-1:0]                    out_tag,
	output logic [gdrm_pkg::DIST_W-1:0]         out_dist
);
	import gdrm_pkg::*;

	localparam int DE_W = ETA_W + 1;
	localparam int SE_W = 2 * ETA_W;
	localparam int SP_W = 2 * PHI_W - 1;

	logic                   v_s1, v_s2, v_s3;
	logic [TAG_W-1:0]       tag_s1, tag_s2, tag_s3;
	logic signed [DE_W-1:0] deta_s1;
	logic signed [PHI_W-1:0] dphi_s1;
	logic [SE_W-1:0]        sqe_s2;
	logic [SP_W-1:0]        sqp_s2;
	logic [DIST_W-1:0]      dist_s3;
	logic signed [DE_W-1:0] deta;
	logic signed [PHI_W-1:0] dphi;
	logic signed [2*DE_W-1:0] sqe_full;
	logic signed [2*PHI_W-1:0] sqp_full;
	logic [SE_W:0]          sum;

	// Phi wraps by keeping only the low bits of the difference.
	assign deta = DE_W'(ref_eta) - DE_W'(cand_eta);
	assign dphi = ref_phi - cand_phi;
	assign sqe_full = deta_s1 * deta_s1;
	assign sqp_full = dphi_s1 * dphi_s1;
	assign sum = (SE_W+1)'(sqe_s2) + (SE_W+1)'(sqp_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1  <= in_tag;
		deta_s1 <= deta;
		dphi_s1 <= dphi;
		tag_s2  <= tag_s1;
		sqe_s2  <= SE_W'(sqe_full);
		sqp_s2  <= SP_W'(sqp_full);
		tag_s3  <= tag_s2;
		dist_s3 <= (sum > (SE_W+1)'(DIST_MAX)) ? DIST_MAX : DIST_W'(sum);
	end

	assign out_valid = v_s3;
	assign out_tag   = tag_s3;
	assign out_dist  = dist_s3;
endmodule
